FILE: src/occ_pkg.sv
// Shared constants, types and helpers for the ordered category CTR block.
`default_nettype none

package occ_pkg;

   localparam int BUCKETS    = 1024;
   localparam int COUNT_BITS = 20;

   localparam int IDX_W   = $clog2(BUCKETS);
   localparam int DOC_W   = 20;
   localparam int BKT_W   = 10;
   localparam int OUT_W   = 20;
   localparam int CTR_W   = 24;
   localparam int PRIOR_W = 24;
   localparam int FRAC_W  = 16;

   // Numerator (good << 16) + prior, divisor total + 1.
   localparam int NUM_W  = COUNT_BITS + FRAC_W + 1;
   localparam int DEN_W  = COUNT_BITS + 1;
   localparam int STEP_W = $clog2(NUM_W + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [CTR_W-1:0]      CTR_MAX   = '1;
   localparam logic [OUT_W-1:0]      OUT_MAX   = '1;

   typedef struct packed {
      logic [COUNT_BITS-1:0] neg;
      logic [COUNT_BITS-1:0] pos;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Saturating increment of one count.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      r = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_BITS'(1);
      return r;
   endfunction

   // Clamps a count to the width of a result field.
   function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
      logic [OUT_W-1:0] r;
      if (33'(v) > 33'(OUT_MAX)) begin
         r = OUT_MAX;
      end else begin
         r = OUT_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/online_ordered_category_ctr.sv
// Ordered category CTR: per-bucket class counts in a table and a bit-serial divider.
//
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_stall  | doc_index, bucket, label
//  rsp_     | out       | rsp_valid/rsp_stall  | doc_index_out, good_count, total_count,
//           |           |                      | ctr_q16
//  csr_     | in        | csr_valid/csr_ready  | prior_q16
//
// A word's table read starts as it is taken; ST_READ then updates the entry and loads the divider,
// ST_DIVIDE runs the restoring divider at one quotient bit per cycle, and ST_DONE moves the
// result into the output register once that register is free.
// After reset the table is cleared one entry per cycle, all BUCKETS entries in turn, while
// req_stall stays high; csr writes are taken at any time.
// A waiting result in the output register does not stop the next word from being taken.
`default_nettype none

module online_ordered_category_ctr (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [occ_pkg::DOC_W-1:0]    req_doc_index,
   input  wire  [occ_pkg::BKT_W-1:0]    req_bucket,
   input  wire                          req_label,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [occ_pkg::DOC_W-1:0]    rsp_doc_index_out,
   output logic [occ_pkg::OUT_W-1:0]    rsp_good_count,
   output logic [occ_pkg::OUT_W-1:0]    rsp_total_count,
   output logic [occ_pkg::CTR_W-1:0]    rsp_ctr_q16,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [occ_pkg::PRIOR_W-1:0]  csr_prior_q16
);

   occ_pkg::state_type state_ff, state_in;

   logic [occ_pkg::IDX_W-1:0]      clr_idx_ff, clr_idx_in;
   logic [occ_pkg::PRIOR_W-1:0]    prior_ff;

   logic [occ_pkg::DOC_W-1:0]      doc_ff, doc_in;
   logic [occ_pkg::BKT_W-1:0]      bucket_ff, bucket_in;
   logic                           label_ff, label_in;

   logic [occ_pkg::OUT_W-1:0]      good_ff, good_in;
   logic [occ_pkg::OUT_W-1:0]      total_ff, total_in;
   logic [occ_pkg::DEN_W-1:0]      den_ff, den_in;
   logic [occ_pkg::DEN_W-1:0]      rem_ff, rem_in;
   logic [occ_pkg::NUM_W-1:0]      quo_ff, quo_in;
   logic [occ_pkg::STEP_W-1:0]     step_ff, step_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [occ_pkg::DOC_W-1:0]      rsp_doc_ff, rsp_doc_in;
   logic [occ_pkg::OUT_W-1:0]      rsp_good_ff, rsp_good_in;
   logic [occ_pkg::OUT_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [occ_pkg::CTR_W-1:0]      rsp_ctr_ff, rsp_ctr_in;

   // Count table, one synchronous read port and one write port.
   occ_pkg::entry_type             mem [occ_pkg::BUCKETS];
   occ_pkg::entry_type             rd_ff;
   logic                           mem_we;
   logic [occ_pkg::IDX_W-1:0]      mem_waddr;
   occ_pkg::entry_type             mem_wdata;
   logic [occ_pkg::IDX_W-1:0]      mem_raddr;

   logic                           req_take;
   logic                           out_free;
   logic                           in_range;
   occ_pkg::entry_type             cur;
   logic [occ_pkg::COUNT_BITS:0]   sum_wide;
   logic [occ_pkg::COUNT_BITS-1:0] total_sat;
   logic [occ_pkg::DEN_W:0]        trial;
   logic                           trial_ge;

   assign req_stall = (state_ff != occ_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign mem_raddr = occ_pkg::IDX_W'(req_bucket);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_doc_index_out = rsp_doc_ff;
   assign rsp_good_count    = rsp_good_ff;
   assign rsp_total_count   = rsp_total_ff;
   assign rsp_ctr_q16       = rsp_ctr_ff;

   // A bucket outside the table reads as zero counts and is never updated.
   assign in_range  = (33'(bucket_ff) < 33'(occ_pkg::BUCKETS));
   assign cur       = in_range ? rd_ff : '0;
   assign sum_wide  = {1'b0, cur.neg} + {1'b0, cur.pos};
   assign total_sat = sum_wide[occ_pkg::COUNT_BITS] ? occ_pkg::COUNT_MAX
                                                    : sum_wide[occ_pkg::COUNT_BITS-1:0];

   // One restoring division step: the next numerator bit enters the partial remainder.
   assign trial    = {rem_ff, quo_ff[occ_pkg::NUM_W-1]};
   assign trial_ge = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= occ_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         prior_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            prior_ff <= csr_prior_q16;
         end
      end
   end

   always_ff @(posedge clock) begin
      doc_ff       <= doc_in;
      bucket_ff    <= bucket_in;
      label_ff     <= label_in;
      good_ff      <= good_in;
      total_ff     <= total_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      rsp_doc_ff   <= rsp_doc_in;
      rsp_good_ff  <= rsp_good_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ctr_ff   <= rsp_ctr_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      doc_in       = doc_ff;
      bucket_in    = bucket_ff;
      label_in     = label_ff;
      good_in      = good_ff;
      total_in     = total_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_doc_in   = rsp_doc_ff;
      rsp_good_in  = rsp_good_ff;
      rsp_total_in = rsp_total_ff;
      rsp_ctr_in   = rsp_ctr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = occ_pkg::IDX_W'(bucket_ff);
      mem_wdata    = cur;

      unique case (state_ff)
         occ_pkg::ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + occ_pkg::IDX_W'(1);
            if (clr_idx_ff == occ_pkg::IDX_W'(occ_pkg::BUCKETS - 1)) begin
               state_in = occ_pkg::ST_IDLE;
            end
         end
         occ_pkg::ST_IDLE: begin
            if (req_take) begin
               doc_in    = req_doc_index;
               bucket_in = req_bucket;
               label_in  = req_label;
               state_in  = occ_pkg::ST_READ;
            end
         end
         occ_pkg::ST_READ: begin
            // Counts go out as they stood before this word; its label is added now.
            good_in  = occ_pkg::clamp_out(cur.pos);
            total_in = occ_pkg::clamp_out(total_sat);
            den_in   = {1'b0, total_sat} + occ_pkg::DEN_W'(1);
            rem_in   = '0;
            quo_in   = {1'b0, cur.pos, occ_pkg::FRAC_W'(0)}
                       + occ_pkg::NUM_W'(prior_ff);
            step_in  = '0;
            mem_we   = in_range;
            if (label_ff) begin
               mem_wdata.pos = occ_pkg::sat_inc(cur.pos);
            end else begin
               mem_wdata.neg = occ_pkg::sat_inc(cur.neg);
            end
            state_in = occ_pkg::ST_DIVIDE;
         end
         occ_pkg::ST_DIVIDE: begin
            if (trial_ge) begin
               rem_in = occ_pkg::DEN_W'(trial - {1'b0, den_ff});
            end else begin
               rem_in = trial[occ_pkg::DEN_W-1:0];
            end
            quo_in  = {quo_ff[occ_pkg::NUM_W-2:0], trial_ge};
            step_in = step_ff + occ_pkg::STEP_W'(1);
            if (step_ff == occ_pkg::STEP_W'(occ_pkg::NUM_W - 1)) begin
               state_in = occ_pkg::ST_DONE;
            end
         end
         occ_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_doc_in   = doc_ff;
               rsp_good_in  = good_ff;
               rsp_total_in = total_ff;
               if (quo_ff > occ_pkg::NUM_W'(occ_pkg::CTR_MAX)) begin
                  rsp_ctr_in = occ_pkg::CTR_MAX;
               end else begin
                  rsp_ctr_in = quo_ff[occ_pkg::CTR_W-1:0];
               end
               state_in = occ_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = occ_pkg::ST_CLEAR;
         end
      endcase
   end

   // A word read from the table must have been taken in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == occ_pkg::ST_READ |-> $past(req_valid && !req_stall))
      else $error("table read state entered without an accepted word");

   // The partial remainder always stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == occ_pkg::ST_DIVIDE |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   // A new result appears only when the divider has finished.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == occ_pkg::ST_DONE))
      else $error("result raised without a finished division");

   // No word is taken while the table is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == occ_pkg::ST_CLEAR |-> req_stall)
      else $error("input open during table clear");

endmodule

`default_nettype wire
